// ===== rtl/icsp_pkg.sv =====
package icsp_pkg;

  // Opcodes of an input item
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ENTER   = 3'd1;
  localparam logic [2:0] OP_EXIT    = 3'd2;
  localparam logic [2:0] OP_SETADDR = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_BIT_TICKS   = 2'd0;
  localparam logic [1:0] REG_ENTRY_WAIT  = 2'd1;
  localparam logic [1:0] REG_EXIT_WAIT   = 2'd2;
  localparam logic [1:0] REG_COMMAND_GAP = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  BitTicksRst   = 8'd1;
  localparam logic [15:0] EntryWaitRst  = 16'd300;
  localparam logic [15:0] ExitWaitRst   = 16'd30000;
  localparam logic [7:0]  CommandGapRst = 8'd2;

  // Serial frame of an address or a read
  localparam int unsigned FrameBits = 24;
  localparam int unsigned AddrBits  = 24;
  localparam logic [FrameBits-1:0] AddrMask =
    {FrameBits{1'b1}} >> (FrameBits - AddrBits);

  // Command bytes
  localparam logic [7:0] CMD_LOAD_PC   = 8'h80;
  localparam logic [7:0] CMD_READ      = 8'hFC;
  localparam logic [7:0] CMD_READ_INC  = 8'hFE;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_ENTER,
    KIND_EXIT,
    KIND_SETADDR,
    KIND_READ
  } kind_e;

  // One classified item
  typedef struct packed {
    kind_e                kind;
    logic [FrameBits-1:0] addr;
    logic [7:0]           cmd_byte;
    logic                 data_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic        reset_level;
    logic        clock_level;
    logic        data_out;
    logic        data_drive;
    logic        busy;
    logic        word_valid;
    logic [15:0] word;
    logic        rejected;
  } result_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  bit_ticks;
    logic [15:0] entry_wait;
    logic [15:0] exit_wait;
    logic [7:0]  command_gap;
  } cfg_t;

endpackage

// ===== rtl/icsp_serial_programming_master.sv =====
// Low-voltage serial programming master. Each transfer on the input channel
// is a tick (one timebase step, with the sampled data-pin level) or a
// command: enter (key sequence), exit (reset pulse), set address or read
// word. Every input transfer yields exactly one output transfer carrying
// the pin levels after that item, the busy flag, a completed read word and
// a flag for a command dropped because a sequence was still running.
// Throughput is one item per clock while the output side is not stalled:
// the pin sequencer in the back end updates its whole state for one item
// at once. An item is first written into a two-entry queue, and the
// sequencer then registers its result in the output register. Write
// the configuration registers only while no items are in flight.
module icsp_serial_programming_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [23:0] address_i,
  input  logic        increment_i,
  input  logic        data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reset_level_o,
  output logic        clock_level_o,
  output logic        data_out_o,
  output logic        data_drive_o,
  output logic        busy_res_o,
  output logic        word_valid_o,
  output logic [15:0] word_o,
  output logic        rejected_o
);
  import icsp_pkg::*;

  logic    push_valid;
  item_t   push_item;
  logic    pop_valid;
  logic    pop;
  item_t   pop_item;
  result_t result;

  icsp_front u_front (
    .in_valid_i   (in_valid_i),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .increment_i  (increment_i),
    .data_in_i    (data_in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  icsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (in_ready_o),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  icsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign reset_level_o = result.reset_level;
  assign clock_level_o = result.clock_level;
  assign data_out_o    = result.data_out;
  assign data_drive_o  = result.data_drive;
  assign busy_res_o    = result.busy;
  assign word_valid_o  = result.word_valid;
  assign word_o        = result.word;
  assign rejected_o    = result.rejected;

endmodule

// ===== rtl/icsp_front.sv =====
module icsp_front (
  input  logic                  in_valid_i,
  input  logic [2:0]            opcode_i,
  input  logic [23:0]           address_i,
  input  logic                  increment_i,
  input  logic                  data_in_i,
  output logic                  push_valid_o,
  output icsp_pkg::item_t       push_item_o
);
  import icsp_pkg::*;

  // Classify the opcode; unknown codes count as ticks
  always_comb begin
    push_item_o.kind     = KIND_TICK;
    push_item_o.cmd_byte = CMD_LOAD_PC;
    // Trim the address to the implemented width
    push_item_o.addr     = address_i & AddrMask;
    push_item_o.data_in  = data_in_i;
    case (opcode_i)
      OP_ENTER:   push_item_o.kind = KIND_ENTER;
      OP_EXIT:    push_item_o.kind = KIND_EXIT;
      OP_SETADDR: push_item_o.kind = KIND_SETADDR;
      OP_READ: begin
        push_item_o.kind     = KIND_READ;
        push_item_o.cmd_byte = increment_i ? CMD_READ_INC : CMD_READ;
      end
      default:    push_item_o.kind = KIND_TICK;
    endcase
  end

  assign push_valid_o = in_valid_i;

endmodule

// ===== rtl/icsp_queue.sv =====
module icsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  icsp_pkg::item_t   push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output icsp_pkg::item_t   pop_item_o
);
  import icsp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            entries_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;
  assign pop_item_o   = entries_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/icsp_back.sv =====
module icsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               item_valid_i,
  input  icsp_pkg::item_t    item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icsp_pkg::result_t  result_o
);
  import icsp_pkg::*;

  // Sequencer phases
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_ENTRY_PRE  = 5'd1;
  localparam logic [4:0] PH_KEY_START  = 5'd2;
  localparam logic [4:0] PH_KEY_LO     = 5'd3;
  localparam logic [4:0] PH_KEY_HI     = 5'd4;
  localparam logic [4:0] PH_ENTRY_POST = 5'd5;
  localparam logic [4:0] PH_EXIT_HIGH  = 5'd6;
  localparam logic [4:0] PH_EXIT_LOW   = 5'd7;
  localparam logic [4:0] PH_EXIT_DONE  = 5'd8;
  localparam logic [4:0] PH_CMD_LO     = 5'd9;
  localparam logic [4:0] PH_CMD_HI     = 5'd10;
  localparam logic [4:0] PH_GAP        = 5'd11;
  localparam logic [4:0] PH_AFTER_GAP  = 5'd12;
  localparam logic [4:0] PH_ADDR_LO    = 5'd13;
  localparam logic [4:0] PH_ADDR_HI    = 5'd14;
  localparam logic [4:0] PH_READ_HI    = 5'd15;
  localparam logic [4:0] PH_READ_LO    = 5'd16;

  // Longest chain of zero-time phase entries in one item
  localparam int unsigned EnterSteps = 4;

  localparam logic [7:0] KeyBytes [4] = '{8'h4D, 8'h43, 8'h48, 8'h50};
  localparam logic [4:0] ByteBits  = 5'd8;
  localparam logic [4:0] FrameCnt  = 5'(FrameBits);
  localparam logic [1:0] LastKey   = 2'd3;

  cfg_t                 cfg_q;
  logic [4:0]           phase_q, phase_d;
  logic [15:0]          wait_q, wait_d;
  logic [4:0]           bit_cnt_q, bit_cnt_d;
  logic [1:0]           key_idx_q, key_idx_d;
  logic [FrameBits-1:0] shift_out_q, shift_out_d;
  logic [FrameBits-1:0] shift_in_q, shift_in_d;
  logic                 pin_rst_q, pin_rst_d;
  logic                 pin_clk_q, pin_clk_d;
  logic                 pin_dat_q, pin_dat_d;
  logic                 pin_drv_q, pin_drv_d;
  logic                 out_valid_q;
  result_t              result_q, result_d;

  logic                 fire, busy;
  logic [7:0]           half;
  logic [4:0]           bc_dec;
  logic [4:0]           bit_pos;
  logic [4:0]           nxt, p;
  logic                 enter_en, run;
  logic                 word_valid, rejected;

  assign fire       = item_valid_i & (~out_valid_q | out_ready_i);
  assign item_pop_o = fire;
  assign busy       = (phase_q != PH_IDLE);
  assign half       = (cfg_q.bit_ticks == '0) ? 8'd1 : cfg_q.bit_ticks;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Apply one item: start a command (or drop it while busy) or step the timebase, then run phase entries
  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    bit_cnt_d   = bit_cnt_q;
    key_idx_d   = key_idx_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    pin_rst_d   = pin_rst_q;
    pin_clk_d   = pin_clk_q;
    pin_dat_d   = pin_dat_q;
    pin_drv_d   = pin_drv_q;
    word_valid  = 1'b0;
    rejected    = 1'b0;
    enter_en    = 1'b0;
    nxt         = PH_IDLE;
    bc_dec      = (bit_cnt_q == '0) ? '0 : bit_cnt_q - 1'b1;
    bit_pos     = '0;
    p           = PH_IDLE;
    run         = 1'b0;

    if (fire) begin
      case (item_i.kind)
        KIND_TICK: begin
          if (busy) begin
            wait_d = (wait_q == '0) ? '0 : wait_q - 1'b1;
            if (wait_d == '0) begin
              enter_en = 1'b1;
              case (phase_q)
                PH_ENTRY_PRE:  nxt = PH_KEY_START;
                PH_KEY_LO:     nxt = PH_KEY_HI;
                PH_KEY_HI: begin
                  bit_cnt_d = bc_dec;
                  if (bc_dec != '0) begin
                    nxt = PH_KEY_LO;
                  end else if (key_idx_q != LastKey) begin
                    key_idx_d   = key_idx_q + 1'b1;
                    shift_out_d = {{(FrameBits-8){1'b0}}, KeyBytes[key_idx_d]};
                    bit_cnt_d   = ByteBits;
                    nxt         = PH_KEY_LO;
                  end else begin
                    nxt = PH_ENTRY_POST;
                  end
                end
                PH_ENTRY_POST: nxt = PH_IDLE;
                PH_EXIT_HIGH:  nxt = PH_EXIT_LOW;
                PH_EXIT_LOW:   nxt = PH_EXIT_DONE;
                PH_CMD_LO:     nxt = PH_CMD_HI;
                PH_CMD_HI: begin
                  bit_cnt_d = bc_dec;
                  nxt       = (bc_dec != '0) ? PH_CMD_LO : PH_GAP;
                end
                PH_GAP:        nxt = PH_AFTER_GAP;
                PH_ADDR_LO:    nxt = PH_ADDR_HI;
                PH_ADDR_HI: begin
                  bit_cnt_d = bc_dec;
                  nxt       = (bc_dec != '0) ? PH_ADDR_LO : PH_IDLE;
                end
                PH_READ_HI:    nxt = PH_READ_LO;
                PH_READ_LO: begin
                  shift_in_d = {shift_in_q[FrameBits-2:0], item_i.data_in};
                  bit_cnt_d  = bc_dec;
                  if (bc_dec != '0) begin
                    nxt = PH_READ_HI;
                  end else begin
                    nxt        = PH_IDLE;
                    word_valid = 1'b1;
                  end
                end
                default:       nxt = PH_IDLE;
              endcase
            end
          end
        end
        KIND_ENTER, KIND_EXIT, KIND_SETADDR, KIND_READ: begin
          if (busy) begin
            rejected = 1'b1;
          end else begin
            enter_en = 1'b1;
            case (item_i.kind)
              KIND_ENTER: nxt = PH_ENTRY_PRE;
              KIND_EXIT:  nxt = PH_EXIT_HIGH;
              KIND_SETADDR: begin
                shift_in_d  = item_i.addr;
                shift_out_d = {{(FrameBits-8){1'b0}}, item_i.cmd_byte};
                bit_cnt_d   = ByteBits;
                nxt         = PH_CMD_LO;
              end
              default: begin
                shift_out_d = {{(FrameBits-8){1'b0}}, item_i.cmd_byte};
                bit_cnt_d   = ByteBits;
                nxt         = PH_CMD_LO;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    // Enter phases; zero-length waits fall through to the next phase
    p   = nxt;
    run = enter_en;
    for (int i = 0; i < EnterSteps; i++) begin
      if (run) begin
        phase_d = p;
        run     = 1'b0;
        case (p)
          PH_ENTRY_PRE: begin
            pin_rst_d = 1'b0;
            pin_clk_d = 1'b0;
            wait_d    = cfg_q.entry_wait;
            if (wait_d == '0) begin
              p   = PH_KEY_START;
              run = 1'b1;
            end
          end
          PH_KEY_START: begin
            key_idx_d   = '0;
            shift_out_d = {{(FrameBits-8){1'b0}}, KeyBytes[0]};
            bit_cnt_d   = ByteBits;
            p           = PH_KEY_LO;
            run         = 1'b1;
          end
          PH_KEY_LO, PH_CMD_LO, PH_ADDR_LO: begin
            bit_pos   = (bit_cnt_d == '0) ? '0 : bit_cnt_d - 1'b1;
            pin_clk_d = 1'b0;
            pin_dat_d = shift_out_d[bit_pos];
            pin_drv_d = 1'b1;
            wait_d    = {8'b0, half};
          end
          PH_KEY_HI, PH_CMD_HI, PH_ADDR_HI: begin
            pin_clk_d = 1'b1;
            wait_d    = {8'b0, half};
          end
          PH_ENTRY_POST: begin
            pin_clk_d = 1'b0;
            pin_dat_d = 1'b0;
            wait_d    = cfg_q.entry_wait;
            if (wait_d == '0) begin
              p   = PH_IDLE;
              run = 1'b1;
            end
          end
          PH_EXIT_HIGH: begin
            pin_rst_d = 1'b1;
            wait_d    = cfg_q.exit_wait;
            if (wait_d == '0) begin
              p   = PH_EXIT_LOW;
              run = 1'b1;
            end
          end
          PH_EXIT_LOW: begin
            pin_rst_d = 1'b0;
            wait_d    = cfg_q.exit_wait;
            if (wait_d == '0) begin
              p   = PH_EXIT_DONE;
              run = 1'b1;
            end
          end
          PH_EXIT_DONE: begin
            pin_rst_d = 1'b1;
            p         = PH_IDLE;
            run       = 1'b1;
          end
          PH_GAP: begin
            pin_clk_d = 1'b0;
            pin_dat_d = 1'b0;
            wait_d    = {8'b0, cfg_q.command_gap};
            if (wait_d == '0) begin
              p   = PH_AFTER_GAP;
              run = 1'b1;
            end
          end
          PH_AFTER_GAP: begin
            bit_cnt_d = FrameCnt;
            if (shift_out_d == {{(FrameBits-8){1'b0}}, CMD_LOAD_PC}) begin
              shift_out_d = shift_in_d;
              p           = PH_ADDR_LO;
            end else begin
              p = PH_READ_HI;
            end
            shift_in_d = '0;
            run        = 1'b1;
          end
          PH_READ_HI: begin
            pin_clk_d = 1'b1;
            pin_drv_d = 1'b0;
            wait_d    = {8'b0, half};
          end
          PH_READ_LO: begin
            pin_clk_d = 1'b0;
            wait_d    = {8'b0, half};
          end
          default: begin
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        endcase
      end
    end

    result_d.reset_level = pin_rst_d;
    result_d.clock_level = pin_clk_d;
    result_d.data_out    = pin_dat_d;
    result_d.data_drive  = pin_drv_d;
    result_d.busy        = (phase_d != PH_IDLE);
    result_d.word_valid  = word_valid;
    result_d.word        = word_valid ? shift_in_d[16:1] : 16'd0;
    result_d.rejected    = rejected;
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_ticks   <= BitTicksRst;
      cfg_q.entry_wait  <= EntryWaitRst;
      cfg_q.exit_wait   <= ExitWaitRst;
      cfg_q.command_gap <= CommandGapRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIT_TICKS:   cfg_q.bit_ticks   <= cfg_data_i[7:0];
        REG_ENTRY_WAIT:  cfg_q.entry_wait  <= cfg_data_i;
        REG_EXIT_WAIT:   cfg_q.exit_wait   <= cfg_data_i;
        REG_COMMAND_GAP: cfg_q.command_gap <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Advance sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      bit_cnt_q   <= '0;
      key_idx_q   <= '0;
      shift_out_q <= '0;
      shift_in_q  <= '0;
      pin_rst_q   <= 1'b1;
      pin_clk_q   <= 1'b0;
      pin_dat_q   <= 1'b0;
      pin_drv_q   <= 1'b1;
    end else if (fire) begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      bit_cnt_q   <= bit_cnt_d;
      key_idx_q   <= key_idx_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      pin_rst_q   <= pin_rst_d;
      pin_clk_q   <= pin_clk_d;
      pin_dat_q   <= pin_dat_d;
      pin_drv_q   <= pin_drv_d;
    end
  end

  // Output register: drop valid once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

endmodule

// ===== rtl/icsp_checker.sv =====
module icsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        clock_level_o,
  input logic        busy_res_o,
  input logic        word_valid_o,
  input logic [15:0] word_o,
  input logic        rejected_o
);

  // A completed read always returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_valid_o |-> !busy_res_o)
    else $error("read word delivered while still busy");

  // A dropped command means a sequence was running and still is
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o && !word_valid_o)
    else $error("rejected result without a running sequence");

  // Word reads as zero unless a read completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_valid_o |-> word_o == 16'd0)
    else $error("word nonzero without word_valid");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_o)
      && $stable(busy_res_o) && $stable(clock_level_o))
    else $error("stalled result changed");

endmodule

bind icsp_serial_programming_master icsp_checker u_icsp_checker (.*);

// ===== verif/tb_icsp_serial_programming_master.sv =====
`timescale 1ns / 1ps

module tb_icsp_serial_programming_master;
  import icsp_pkg::*;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned ShownLimit = 10;

  // Opcodes above the read command decode as ticks
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // Entry key, first byte in the top bits
  localparam logic [31:0] EntryKey = 32'h4D43_4850;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENTRY_PRE,
    S_KEY_START,
    S_KEY_LO,
    S_KEY_HI,
    S_ENTRY_POST,
    S_EXIT_HIGH,
    S_EXIT_LOW,
    S_EXIT_DONE,
    S_CMD_LO,
    S_CMD_HI,
    S_GAP,
    S_AFTER_GAP,
    S_ADDR_LO,
    S_ADDR_HI,
    S_READ_HI,
    S_READ_LO
  } seq_phase_e;

  typedef enum int {
    DIN_ZERO,
    DIN_ONE,
    DIN_RANDOM
  } din_mode_e;

  // Pin sequencer predictor and the queue of pin levels it expects
  class icsp_pin_predictor;
    logic [7:0]  bit_ticks;
    logic [15:0] entry_wait;
    logic [15:0] exit_wait;
    logic [7:0]  command_gap;
    seq_phase_e  phase;
    logic [15:0] wait_count;
    logic [4:0]  bit_count;
    logic [1:0]  key_index;
    logic [23:0] shift_out;
    logic [23:0] shift_in;
    logic        rst_pin;
    logic        clk_pin;
    logic        dat_pin;
    logic        drv_pin;
    result_t     expected_pins[$];
    int          mismatches;

    function new();
      bit_ticks   = BitTicksRst;
      entry_wait  = EntryWaitRst;
      exit_wait   = ExitWaitRst;
      command_gap = CommandGapRst;
      phase       = S_IDLE;
      wait_count  = '0;
      bit_count   = '0;
      key_index   = '0;
      shift_out   = '0;
      shift_in    = '0;
      rst_pin     = 1'b1;
      clk_pin     = 1'b0;
      dat_pin     = 1'b0;
      drv_pin     = 1'b1;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_BIT_TICKS:   bit_ticks = data[7:0];
        REG_ENTRY_WAIT:  entry_wait = data;
        REG_EXIT_WAIT:   exit_wait = data;
        REG_COMMAND_GAP: command_gap = data[7:0];
        default: ;
      endcase
    endfunction

    function bit seq_busy();
      return phase != S_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function logic [15:0] half_ticks();
      return (bit_ticks == 8'd0) ? 16'd1 : {8'd0, bit_ticks};
    endfunction

    // Bit about to be sent, counted down from the top of the frame
    function logic send_bit();
      int pos;
      pos = (bit_count == 5'd0) ? 0 : int'(bit_count) - 1;
      return shift_out[pos];
    endfunction

    // Move into a phase, falling through zero-length waits at once
    function void enter_phase(seq_phase_e target);
      seq_phase_e p;
      bit         settled;
      p = target;
      settled = 1'b0;
      while (!settled) begin
        phase = p;
        settled = 1'b1;
        case (p)
          S_ENTRY_PRE: begin
            rst_pin = 1'b0;
            clk_pin = 1'b0;
            wait_count = entry_wait;
            if (wait_count == 16'd0) begin
              p = S_KEY_START;
              settled = 1'b0;
            end
          end
          S_KEY_START: begin
            key_index = 2'd0;
            shift_out = {16'd0, EntryKey[31:24]};
            bit_count = 5'd8;
            p = S_KEY_LO;
            settled = 1'b0;
          end
          S_KEY_LO, S_CMD_LO, S_ADDR_LO: begin
            clk_pin = 1'b0;
            dat_pin = send_bit();
            drv_pin = 1'b1;
            wait_count = half_ticks();
          end
          S_KEY_HI, S_CMD_HI, S_ADDR_HI: begin
            clk_pin = 1'b1;
            wait_count = half_ticks();
          end
          S_ENTRY_POST: begin
            clk_pin = 1'b0;
            dat_pin = 1'b0;
            wait_count = entry_wait;
            if (wait_count == 16'd0) begin
              p = S_IDLE;
              settled = 1'b0;
            end
          end
          S_EXIT_HIGH: begin
            rst_pin = 1'b1;
            wait_count = exit_wait;
            if (wait_count == 16'd0) begin
              p = S_EXIT_LOW;
              settled = 1'b0;
            end
          end
          S_EXIT_LOW: begin
            rst_pin = 1'b0;
            wait_count = exit_wait;
            if (wait_count == 16'd0) begin
              p = S_EXIT_DONE;
              settled = 1'b0;
            end
          end
          S_EXIT_DONE: begin
            rst_pin = 1'b1;
            p = S_IDLE;
            settled = 1'b0;
          end
          S_GAP: begin
            clk_pin = 1'b0;
            dat_pin = 1'b0;
            wait_count = {8'd0, command_gap};
            if (wait_count == 16'd0) begin
              p = S_AFTER_GAP;
              settled = 1'b0;
            end
          end
          S_AFTER_GAP: begin
            // Load the held address for a set-address, else open the read frame
            bit_count = 5'd24;
            if (shift_out == {16'd0, CMD_LOAD_PC}) begin
              shift_out = shift_in & AddrMask;
              shift_in = '0;
              p = S_ADDR_LO;
            end else begin
              shift_in = '0;
              p = S_READ_HI;
            end
            settled = 1'b0;
          end
          S_READ_HI: begin
            clk_pin = 1'b1;
            drv_pin = 1'b0;
            wait_count = half_ticks();
          end
          S_READ_LO: begin
            clk_pin = 1'b0;
            wait_count = half_ticks();
          end
          default: begin
            phase = S_IDLE;
            wait_count = '0;
          end
        endcase
      end
    endfunction

    // Leave a phase whose wait ran out; return 1 when a read word completes
    function bit expire_phase(logic din);
      case (phase)
        S_ENTRY_PRE:  enter_phase(S_KEY_START);
        S_KEY_LO:     enter_phase(S_KEY_HI);
        S_KEY_HI: begin
          if (bit_count != 5'd0) bit_count = bit_count - 5'd1;
          if (bit_count != 5'd0) begin
            enter_phase(S_KEY_LO);
          end else if (key_index < 2'd3) begin
            key_index = key_index + 2'd1;
            shift_out = {16'd0, EntryKey[8 * (3 - int'(key_index)) +: 8]};
            bit_count = 5'd8;
            enter_phase(S_KEY_LO);
          end else begin
            enter_phase(S_ENTRY_POST);
          end
        end
        S_ENTRY_POST: enter_phase(S_IDLE);
        S_EXIT_HIGH:  enter_phase(S_EXIT_LOW);
        S_EXIT_LOW:   enter_phase(S_EXIT_DONE);
        S_CMD_LO:     enter_phase(S_CMD_HI);
        S_CMD_HI: begin
          if (bit_count != 5'd0) bit_count = bit_count - 5'd1;
          enter_phase(bit_count != 5'd0 ? S_CMD_LO : S_GAP);
        end
        S_GAP:        enter_phase(S_AFTER_GAP);
        S_ADDR_LO:    enter_phase(S_ADDR_HI);
        S_ADDR_HI: begin
          if (bit_count != 5'd0) bit_count = bit_count - 5'd1;
          enter_phase(bit_count != 5'd0 ? S_ADDR_LO : S_IDLE);
        end
        S_READ_HI:    enter_phase(S_READ_LO);
        S_READ_LO: begin
          shift_in = {shift_in[22:0], din};
          if (bit_count != 5'd0) bit_count = bit_count - 5'd1;
          if (bit_count != 5'd0) begin
            enter_phase(S_READ_HI);
          end else begin
            enter_phase(S_IDLE);
            return 1'b1;
          end
        end
        default:      enter_phase(S_IDLE);
      endcase
      return 1'b0;
    endfunction

    // Predict the pin levels that follow one input transfer
    function void note_item(logic [2:0] op, logic [23:0] addr, logic inc, logic din);
      result_t pins;
      bit      was_busy;
      bit      got_word;
      bit      dropped;
      was_busy = seq_busy();
      got_word = 1'b0;
      dropped = 1'b0;
      if (op >= OP_ENTER && op <= OP_READ) begin
        if (was_busy) begin
          dropped = 1'b1;
        end else begin
          case (op)
            OP_ENTER: enter_phase(S_ENTRY_PRE);
            OP_EXIT:  enter_phase(S_EXIT_HIGH);
            OP_SETADDR: begin
              shift_in = addr & AddrMask;
              shift_out = {16'd0, CMD_LOAD_PC};
              bit_count = 5'd8;
              enter_phase(S_CMD_LO);
            end
            default: begin
              shift_out = {16'd0, inc ? CMD_READ_INC : CMD_READ};
              bit_count = 5'd8;
              enter_phase(S_CMD_LO);
            end
          endcase
        end
      end else if (was_busy) begin
        if (wait_count != 16'd0) wait_count = wait_count - 16'd1;
        if (wait_count == 16'd0) got_word = expire_phase(din);
      end
      pins.reset_level = rst_pin;
      pins.clock_level = clk_pin;
      pins.data_out    = dat_pin;
      pins.data_drive  = drv_pin;
      pins.busy        = seq_busy();
      pins.word_valid  = got_word;
      pins.word        = got_word ? shift_in[16:1] : 16'd0;
      pins.rejected    = dropped;
      expected_pins.push_back(pins);
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= ShownLimit) begin
        $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
      end
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) flag(what, want, got);
    endfunction

    // Compare one output transfer against the oldest prediction
    function void check_pins(result_t got);
      result_t want;
      if (expected_pins.size() == 0) begin
        flag("output transfer with nothing pending", 16'd0, 16'd0);
        return;
      end
      want = expected_pins.pop_front();
      compare("reset_level", 16'(want.reset_level), 16'(got.reset_level));
      compare("clock_level", 16'(want.clock_level), 16'(got.clock_level));
      compare("data_out", 16'(want.data_out), 16'(got.data_out));
      compare("data_drive", 16'(want.data_drive), 16'(got.data_drive));
      compare("busy_res", 16'(want.busy), 16'(got.busy));
      compare("word_valid", 16'(want.word_valid), 16'(got.word_valid));
      compare("word", want.word, got.word);
      compare("rejected", 16'(want.rejected), 16'(got.rejected));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = OP_TICK;
  logic [23:0] address_i = '0;
  logic        increment_i = 1'b0;
  logic        data_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        reset_level_o;
  logic        clock_level_o;
  logic        data_out_o;
  logic        data_drive_o;
  logic        busy_res_o;
  logic        word_valid_o;
  logic [15:0] word_o;
  logic        rejected_o;

  icsp_pin_predictor pin_seq = new();

  int          send_idle_pct = 23;
  int          recv_idle_pct = 47;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  icsp_serial_programming_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .increment_i   (increment_i),
    .data_in_i     (data_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reset_level_o (reset_level_o),
    .clock_level_o (clock_level_o),
    .data_out_o    (data_out_o),
    .data_drive_o  (data_drive_o),
    .busy_res_o    (busy_res_o),
    .word_valid_o  (word_valid_o),
    .word_o        (word_o),
    .rejected_o    (rejected_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Stall the output side at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check output transfers before noting the input transfer of the same edge
  always @(posedge clk_i) begin : watch_transfers
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.reset_level = reset_level_o;
        seen.clock_level = clock_level_o;
        seen.data_out    = data_out_o;
        seen.data_drive  = data_drive_o;
        seen.busy        = busy_res_o;
        seen.word_valid  = word_valid_o;
        seen.word        = word_o;
        seen.rejected    = rejected_o;
        pin_seq.check_pins(seen);
      end
      if (in_valid_i && in_ready_o) begin
        pin_seq.note_item(opcode_i, address_i, increment_i, data_in_i);
      end
    end
  end

  // Offer one item, idling first at random; return at the falling edge after the transfer
  task automatic send_item(logic [2:0] op, logic [23:0] addr, logic inc, logic din);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    address_i   <= addr;
    increment_i <= inc;
    data_in_i   <= din;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Tick until the sequence ends, with dropped commands and spare opcodes mixed in
  task automatic finish_sequence(din_mode_e mode, int noise_pct);
    int  roll;
    logic din;
    while (pin_seq.seq_busy()) begin
      roll = int'($urandom_range(0, 99));
      din = (mode == DIN_ZERO) ? 1'b0 : (mode == DIN_ONE) ? 1'b1 : 1'($urandom_range(0, 1));
      if (roll < noise_pct) begin
        send_item(3'($urandom_range(OP_ENTER, OP_READ)), 24'($urandom),
                  1'($urandom_range(0, 1)), din);
      end else if (roll < 2 * noise_pct) begin
        send_item(3'($urandom_range(OpSpareLo, OpSpareHi)), 24'($urandom),
                  1'($urandom_range(0, 1)), din);
      end else begin
        send_item(OP_TICK, 24'($urandom), 1'($urandom_range(0, 1)), din);
      end
    end
  endtask

  // Hold the input side until every prediction has been matched
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pin_seq.pending() != 0) @(negedge clk_i);
  endtask

  // Finish the sequence, drain, and let the pipeline settle
  task automatic quiesce();
    finish_sequence(DIN_RANDOM, 0);
    hold_until_drained();
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    pin_seq.set_reg(idx, data);
  endtask

  task automatic configure(logic [15:0] ticks, logic [15:0] entry, logic [15:0] leave,
                           logic [15:0] gap);
    quiesce();
    put_reg(REG_BIT_TICKS, ticks);
    put_reg(REG_ENTRY_WAIT, entry);
    put_reg(REG_EXIT_WAIT, leave);
    put_reg(REG_COMMAND_GAP, gap);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly whole command sequences with random content, some noise
  task automatic random_round(int n_items);
    int          first;
    int          roll;
    int          pick;
    bit          held;
    logic [2:0]  op;
    logic [23:0] addr;
    first = items_sent;
    held = 1'b0;
    while (items_sent - first < n_items) begin
      if (!held && items_sent - first > n_items / 2) begin
        hold_until_drained();
        held = 1'b1;
      end
      roll = int'($urandom_range(0, 99));
      if (roll < 10) begin
        send_item(3'($urandom_range(0, 7)), 24'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        op = (roll < 50) ? OP_READ : (roll < 75) ? OP_SETADDR :
             (roll < 90) ? OP_ENTER : OP_EXIT;
        pick = int'($urandom_range(0, 9));
        addr = (pick == 0) ? 24'h00_0000 : (pick == 1) ? 24'hFF_FFFF : 24'($urandom);
        send_item(op, addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        finish_sequence(DIN_RANDOM, 4);
      end
    end
  endtask

  initial begin : timeout
    wait (cycle_count >= CycleLimit);
    $display("[icsp_serial_programming_master] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: idle ticks, spare opcode, read of all ones, address extremes
    send_item(OP_TICK, 24'h00_0000, 1'b0, 1'b1);
    send_item(OpSpareHi, 24'hFF_FFFF, 1'b1, 1'b1);
    send_item(OP_READ, 24'h00_0000, 1'b1, 1'b0);
    finish_sequence(DIN_ONE, 0);
    send_item(OP_SETADDR, 24'hFF_FFFF, 1'b0, 1'b0);
    send_item(OP_ENTER, 24'h00_0000, 1'b0, 1'b0);
    send_item(OpSpareLo, 24'h12_3456, 1'b0, 1'b1);
    finish_sequence(DIN_RANDOM, 0);
    send_item(OP_SETADDR, 24'h00_0000, 1'b1, 1'b1);
    finish_sequence(DIN_ZERO, 0);

    // Zero entry, exit and gap waits; commands while busy are dropped
    configure(16'd1, 16'd0, 16'd0, 16'd0);
    send_item(OP_ENTER, 24'h00_0000, 1'b0, 1'b0);
    send_item(OP_READ, 24'h00_0000, 1'b1, 1'b0);
    send_item(OP_EXIT, 24'h00_0000, 1'b0, 1'b0);
    send_item(OP_SETADDR, 24'hA5_5AA5, 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 0);
    send_item(OP_EXIT, 24'h00_0000, 1'b0, 1'b0);
    send_item(OP_READ, 24'h00_0000, 1'b0, 1'b1);
    finish_sequence(DIN_ZERO, 0);
    send_item(OP_READ, 24'h00_0000, 1'b1, 1'b1);
    finish_sequence(DIN_RANDOM, 0);

    // Zero half-step count with junk in the upper data bits, one-tick waits
    configure(16'hA500, 16'd1, 16'd1, 16'hFF01);
    send_item(OP_EXIT, 24'h00_0000, 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 0);
    send_item(OP_ENTER, 24'h00_0000, 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 0);
    send_item(OP_SETADDR, 24'h5A_A55A, 1'b1, 1'b0);
    finish_sequence(DIN_RANDOM, 0);

    // Random rounds under three idling schemes, each with fresh small settings
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 23 : 0;
      for (int round = 0; round < 2; round++) begin
        configure({8'($urandom), 8'($urandom_range(0, 3))}, 16'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)), {8'($urandom), 8'($urandom_range(0, 4))});
        random_round(30);
      end
    end

    // Longer waits and gap, one run of every command
    configure(16'h0001, 16'h0010, 16'h0010, 16'h0008);
    send_item(OP_ENTER, 24'h00_0000, 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 1);
    send_item(OP_EXIT, 24'h00_0000, 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 1);
    send_item(OP_SETADDR, 24'($urandom), 1'b0, 1'b0);
    finish_sequence(DIN_RANDOM, 1);
    send_item(OP_READ, 24'h00_0000, 1'b1, 1'b0);
    finish_sequence(DIN_RANDOM, 1);

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (pin_seq.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (pin_seq.mismatches == 0 && pin_seq.pending() == 0) begin
      $display("[icsp_serial_programming_master] OK");
    end else begin
      $display("[icsp_serial_programming_master] ERROR");
    end
    $finish;
  end

endmodule
